FILE: rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the C-subset token scanner
// Token codes, byte classes, transaction structs and the keyword lookup.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned KwDepth = 6;
  localparam int unsigned KwIdxW  = $clog2(KwDepth);

  typedef enum logic [0:0] {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    TOK_EOF     = 5'd0,
    TOK_IDENT   = 5'd1,
    TOK_NUMBER  = 5'd2,
    TOK_STRING  = 5'd3,
    TOK_KW_INT  = 5'd4,
    TOK_KW_VOID = 5'd5,
    TOK_KW_RET  = 5'd6,
    TOK_KW_IF   = 5'd7,
    TOK_KW_ELSE = 5'd8,
    TOK_KW_WHL  = 5'd9,
    TOK_KW_FOR  = 5'd10,
    TOK_LPAREN  = 5'd11,
    TOK_RPAREN  = 5'd12,
    TOK_LBRACE  = 5'd13,
    TOK_RBRACE  = 5'd14,
    TOK_SEMI    = 5'd15,
    TOK_COMMA   = 5'd16,
    TOK_ASSIGN  = 5'd17,
    TOK_PLUS    = 5'd18,
    TOK_MINUS   = 5'd19,
    TOK_STAR    = 5'd20,
    TOK_SLASH   = 5'd21,
    TOK_UNKNOWN = 5'd22
  } tok_type_e;

  typedef enum logic [2:0] {
    CLS_SPACE   = 3'd0,
    CLS_NEWLINE = 3'd1,
    CLS_ALPHA   = 3'd2,
    CLS_DIGIT   = 3'd3,
    CLS_SLASH   = 3'd4,
    CLS_STAR    = 3'd5,
    CLS_QUOTE   = 3'd6,
    CLS_OTHER   = 3'd7
  } cls_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] source_byte;
  } in_item_t;

  typedef struct packed {
    tok_type_e        token_type;
    logic [POS_W-1:0] start_line;
    logic [POS_W-1:0] start_column;
    logic [LEN_W-1:0] token_length;
    logic [7:0]       single_byte;
    logic             last_of_run;
  } out_tok_t;

  typedef struct packed {
    logic       eof;
    cls_e       cls;
    tok_type_e  direct_type;
    logic [7:0] source_byte;
  } cmd_t;

  typedef logic [KwDepth-1:0][7:0] kw_buf_t;

  function automatic tok_type_e kw_lookup(kw_buf_t buf_i, logic [LEN_W-1:0] len_i);
    logic [8*KwDepth-1:0] w;
    tok_type_e            t;
    w = {buf_i[0], buf_i[1], buf_i[2], buf_i[3], buf_i[4], buf_i[5]};
    t = TOK_IDENT;
    if (len_i == LEN_W'(3) && w == {"int", 24'h0}) t = TOK_KW_INT;
    if (len_i == LEN_W'(4) && w == {"void", 16'h0}) t = TOK_KW_VOID;
    if (len_i == LEN_W'(6) && w == "return") t = TOK_KW_RET;
    if (len_i == LEN_W'(2) && w == {"if", 32'h0}) t = TOK_KW_IF;
    if (len_i == LEN_W'(4) && w == {"else", 16'h0}) t = TOK_KW_ELSE;
    if (len_i == LEN_W'(5) && w == {"while", 8'h0}) t = TOK_KW_WHL;
    if (len_i == LEN_W'(3) && w == {"for", 24'h0}) t = TOK_KW_FOR;
    return t;
  endfunction

endpackage

FILE: rtl/core/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front: input classifier and command queue
// Classifies each accepted byte and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module cst_front import cst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       push;
  logic [7:0] b;

  always_comb begin
    b = in_item_i.source_byte;
    cmd_new.eof         = (in_item_i.kind == KIND_END);
    cmd_new.source_byte = b;
    cmd_new.direct_type = TOK_UNKNOWN;
    case (b)
      "(": cmd_new.direct_type = TOK_LPAREN;
      ")": cmd_new.direct_type = TOK_RPAREN;
      "{": cmd_new.direct_type = TOK_LBRACE;
      "}": cmd_new.direct_type = TOK_RBRACE;
      ";": cmd_new.direct_type = TOK_SEMI;
      ",": cmd_new.direct_type = TOK_COMMA;
      "=": cmd_new.direct_type = TOK_ASSIGN;
      "+": cmd_new.direct_type = TOK_PLUS;
      "-": cmd_new.direct_type = TOK_MINUS;
      "*": cmd_new.direct_type = TOK_STAR;
      "/": cmd_new.direct_type = TOK_SLASH;
      default: cmd_new.direct_type = TOK_UNKNOWN;
    endcase
    if (b == 8'h0A) begin
      cmd_new.cls = CLS_NEWLINE;
    end else if (b == " " || b inside {[8'd9:8'd13]}) begin
      cmd_new.cls = CLS_SPACE;
    end else if (b inside {["a":"z"], ["A":"Z"]} || b == "_") begin
      cmd_new.cls = CLS_ALPHA;
    end else if (b inside {["0":"9"]}) begin
      cmd_new.cls = CLS_DIGIT;
    end else if (b == "/") begin
      cmd_new.cls = CLS_SLASH;
    end else if (b == "*") begin
      cmd_new.cls = CLS_STAR;
    end else if (b == "\"") begin
      cmd_new.cls = CLS_QUOTE;
    end else begin
      cmd_new.cls = CLS_OTHER;
    end
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = cmd_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_new;
    end
  end

endmodule

FILE: rtl/core/cst_back.sv
// ----------------------------------------------------------------------------
// cst_back: token scanner and result queue
// Runs the scan state machine on queued commands and buffers emitted tokens.
// ----------------------------------------------------------------------------
module cst_back import cst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_pop_o,
  input  cmd_t     cmd_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_tok_t out_tok_o
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_IDENT = 3'd1;
  localparam logic [2:0] MODE_NUM   = 3'd2;
  localparam logic [2:0] MODE_STR   = 3'd3;
  localparam logic [2:0] MODE_SLASH = 3'd4;
  localparam logic [2:0] MODE_LCMT  = 3'd5;
  localparam logic [2:0] MODE_BCMT  = 3'd6;
  localparam logic [2:0] MODE_BSTAR = 3'd7;

  localparam logic [POS_W-1:0] PosMax = '1;
  localparam logic [LEN_W-1:0] LenMax = '1;

  logic [2:0]       mode_q, mode_d;
  kw_buf_t          kw_q, kw_d;
  logic [POS_W-1:0] line_q, line_d, col_q, col_d;
  logic [POS_W-1:0] tline_q, tline_d, tcol_q, tcol_d;
  logic [LEN_W-1:0] len_q, len_d;

  out_tok_t   oq_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop_out;

  logic       do_pend, do_start, emit2;
  out_tok_t   pend_tok, tok2, res_a, res_b;
  logic [1:0] n_push;
  logic [7:0] b;
  cls_e       c;

  assign cmd_pop_o = cmd_valid_i && (cnt_q <= 3'd2);
  assign b         = cmd_i.source_byte;
  assign c         = cmd_i.cls;

  always_comb begin
    mode_d   = mode_q;
    kw_d     = kw_q;
    line_d   = line_q;
    col_d    = col_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    len_d    = len_q;
    do_pend  = 1'b0;
    do_start = 1'b0;
    emit2    = 1'b0;

    pend_tok.start_line   = tline_q;
    pend_tok.start_column = tcol_q;
    pend_tok.token_length = len_q;
    pend_tok.single_byte  = 8'h00;
    pend_tok.last_of_run  = 1'b0;
    case (mode_q)
      MODE_IDENT: pend_tok.token_type = kw_lookup(kw_q, len_q);
      MODE_NUM:   pend_tok.token_type = TOK_NUMBER;
      MODE_STR:   pend_tok.token_type = TOK_STRING;
      default: begin
        pend_tok.token_type   = TOK_SLASH;
        pend_tok.token_length = LEN_W'(1);
        pend_tok.single_byte  = "/";
      end
    endcase

    tok2.token_type   = cmd_i.direct_type;
    tok2.start_line   = line_q;
    tok2.start_column = col_q;
    tok2.token_length = LEN_W'(1);
    tok2.single_byte  = b;
    tok2.last_of_run  = 1'b1;

    if (cmd_i.eof) begin
      do_pend = (mode_q inside {MODE_IDENT, MODE_NUM, MODE_STR, MODE_SLASH});
      emit2   = 1'b1;
      tok2.token_type   = TOK_EOF;
      tok2.token_length = '0;
      tok2.single_byte  = 8'h00;
      mode_d  = MODE_IDLE;
      kw_d    = '0;
      line_d  = POS_W'(1);
      col_d   = POS_W'(1);
      tline_d = POS_W'(1);
      tcol_d  = POS_W'(1);
      len_d   = '0;
    end else begin
      case (mode_q)
        MODE_IDENT: begin
          if (c == CLS_ALPHA || c == CLS_DIGIT) begin
            if (len_q < LEN_W'(KwDepth)) kw_d[len_q[KwIdxW-1:0]] = b;
            if (len_q != LenMax) len_d = len_q + LEN_W'(1);
          end else begin
            do_pend  = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_NUM: begin
          if (c == CLS_DIGIT) begin
            if (len_q != LenMax) len_d = len_q + LEN_W'(1);
          end else begin
            do_pend  = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == CLS_QUOTE) begin
            do_pend = 1'b1;
            mode_d  = MODE_IDLE;
          end else if (len_q != LenMax) begin
            len_d = len_q + LEN_W'(1);
          end
        end
        MODE_SLASH: begin
          if (c == CLS_SLASH) begin
            mode_d = MODE_LCMT;
          end else if (c == CLS_STAR) begin
            mode_d = MODE_BCMT;
          end else begin
            do_pend  = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_LCMT: begin
          if (c == CLS_NEWLINE) mode_d = MODE_IDLE;
        end
        MODE_BCMT: begin
          if (c == CLS_STAR) mode_d = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (c == CLS_SLASH) mode_d = MODE_IDLE;
          else if (c != CLS_STAR) mode_d = MODE_BCMT;
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_d = MODE_IDLE;
        case (c)
          CLS_SPACE, CLS_NEWLINE: mode_d = MODE_IDLE;
          CLS_ALPHA: begin
            tline_d = line_q;
            tcol_d  = col_q;
            kw_d    = '0;
            kw_d[0] = b;
            len_d   = LEN_W'(1);
            mode_d  = MODE_IDENT;
          end
          CLS_DIGIT: begin
            tline_d = line_q;
            tcol_d  = col_q;
            len_d   = LEN_W'(1);
            mode_d  = MODE_NUM;
          end
          CLS_SLASH: begin
            tline_d = line_q;
            tcol_d  = col_q;
            mode_d  = MODE_SLASH;
          end
          CLS_QUOTE: begin
            tline_d = line_q;
            tcol_d  = col_q;
            len_d   = '0;
            mode_d  = MODE_STR;
          end
          default: emit2 = 1'b1;
        endcase
      end

      if (c == CLS_NEWLINE) begin
        if (line_q != PosMax) line_d = line_q + POS_W'(1);
        col_d = POS_W'(1);
      end else if (col_q != PosMax) begin
        col_d = col_q + POS_W'(1);
      end
    end

    res_b = tok2;
    if (do_pend) begin
      res_a             = pend_tok;
      res_a.last_of_run = !emit2;
    end else begin
      res_a = tok2;
    end
    n_push = 2'(do_pend) + 2'(emit2);
  end

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_tok_o   = oq_q[rd_q];
  assign pop_out     = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q - 3'(pop_out);
    if (cmd_pop_o) cnt_d = cnt_d + 3'(n_push);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      kw_q    <= '0;
      line_q  <= POS_W'(1);
      col_q   <= POS_W'(1);
      tline_q <= POS_W'(1);
      tcol_q  <= POS_W'(1);
      len_q   <= '0;
      wr_q    <= 2'd0;
      rd_q    <= 2'd0;
      cnt_q   <= 3'd0;
    end else begin
      if (cmd_pop_o) begin
        mode_q  <= mode_d;
        kw_q    <= kw_d;
        line_q  <= line_d;
        col_q   <= col_d;
        tline_q <= tline_d;
        tcol_q  <= tcol_d;
        len_q   <= len_d;
        wr_q    <= wr_q + n_push;
      end
      if (pop_out) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && n_push != 2'd0) begin
      oq_q[wr_q] <= res_a;
    end
    if (cmd_pop_o && n_push == 2'd2) begin
      oq_q[wr_q + 2'd1] <= res_b;
    end
  end

endmodule

FILE: rtl/core/c_subset_token_scanner.sv
// ----------------------------------------------------------------------------
// c_subset_token_scanner: C-subset lexical scanner top level
// Front classifier and queue feeding the scan engine and its result queue.
// ----------------------------------------------------------------------------
// The scanner takes one source byte per cycle while in_stall_o is low. Each
// accepted byte is classified and written to the front queue; the scan engine
// pops it when the result queue holds at most two tokens, scans it, and writes
// the tokens it causes to the result queue, which presents them at the output.
// A byte that closes one token and emits an operator or unknown token, and the
// end marker after a pending token, give two tokens, which leave one at a time
// through the single read port of the four-entry result queue; all other
// bytes sustain one byte per cycle as long as the output is not stalled.
module c_subset_token_scanner import cst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_tok_t out_tok_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  cst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  cst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tok_o   (out_tok_o)
  );

endmodule

FILE: rtl/core/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker: port-level checks of the token scanner
// Protocol and token-shape properties, bound to the top level.
// ----------------------------------------------------------------------------
module cst_checker import cst_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_item_t in_item_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_tok_t out_tok_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_tok_o))
    else $error("stalled result transaction changed");

  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_tok_o.token_type == TOK_EOF |->
      out_tok_o.last_of_run && out_tok_o.token_length == '0 &&
      out_tok_o.single_byte == 8'h00)
    else $error("malformed eof token");

  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_tok_o.token_type >= TOK_LPAREN |->
      out_tok_o.token_length == LEN_W'(1))
    else $error("one-character token with wrong length");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_tok_o.start_line != '0 && out_tok_o.start_column != '0)
    else $error("token position zero");

  a_multi_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_tok_o.token_type >= TOK_IDENT &&
      out_tok_o.token_type <= TOK_KW_FOR |-> out_tok_o.single_byte == 8'h00)
    else $error("multi-character token carries a byte");

endmodule

bind c_subset_token_scanner cst_checker u_cst_checker (.*);
